FILE: rtl/core/imabd_pkg.sv
// Package for the IMA ADPCM block decoder.
// Holds the step-size table, the index adaptation rule and the shared widths.
// No dependencies.
package imabd_pkg;

    localparam int SampleW = 16;
    localparam int IndexW  = 7;
    localparam int StepW   = 15;
    localparam int CodeW   = 4;

    localparam logic [IndexW-1:0] MaxStepPos = 7'd88;

    typedef enum logic {
        OP_HEADER = 1'b0,
        OP_CODE   = 1'b1
    } t_opcode;

    localparam logic [StepW-1:0] STEP_SIZES [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,
        15'd12,    15'd13,    15'd14,    15'd16,    15'd17,
        15'd19,    15'd21,    15'd23,    15'd25,    15'd28,
        15'd31,    15'd34,    15'd37,    15'd41,    15'd45,
        15'd50,    15'd55,    15'd60,    15'd66,    15'd73,
        15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
        15'd337,   15'd371,   15'd408,   15'd449,   15'd494,
        15'd544,   15'd598,   15'd658,   15'd724,   15'd796,
        15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,
        15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,
        15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,
        15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
        15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
        15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    // Indexes past the table read the last entry.
    function automatic logic [StepW-1:0] step_size(input logic [IndexW-1:0] idx);
        logic [StepW-1:0] s;
        if (idx > MaxStepPos) begin
            s = STEP_SIZES[88];
        end else begin
            s = STEP_SIZES[idx];
        end
        return s;
    endfunction

    // Index move from the magnitude bits of a code.
    function automatic logic signed [4:0] index_move(input logic [2:0] mag);
        logic signed [4:0] m;
        unique case (mag)
            3'd4:    m = 5'sd2;
            3'd5:    m = 5'sd4;
            3'd6:    m = 5'sd6;
            3'd7:    m = 5'sd8;
            default: m = -5'sd1;
        endcase
        return m;
    endfunction

    function automatic logic [IndexW-1:0] clamp_index(input logic [IndexW-1:0] idx);
        return (idx > MaxStepPos) ? MaxStepPos : idx;
    endfunction

endpackage

FILE: rtl/core/ima_adpcm_block_decoder.sv
// IMA ADPCM block decoder (mono): header beats seed the predictor and index,
// code beats give two samples each. Uses imabd_pkg and imabd_nibble.
//
// One beat is taken per clock while the output side is not stalled. A beat is
// registered on entry, both nibbles of a code byte are decoded combinationally
// by two chained nibble steps that update the predictor and index, and the pair
// of samples lands in an output register once that register is free.
// A header beat yields no result.
// Input tuser[0] is the opcode: 0 = block header, 1 = code byte. Input tdata,
// from bit 0: seed_predictor[15:0], seed_index[22:16], code_byte[30:23], zero
// pad [31]. Output tdata, from bit 0: first_sample[15:0], second_sample[31:16].
// Seed indexes above 88 are clamped to 88; the predictor saturates to 16 bits.
module ima_adpcm_block_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // seed_predictor, seed_index, code_byte, pad
    input  logic [0:0]  i_s_axis_tuser,  // opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // first_sample, second_sample
);
    import imabd_pkg::*;

    logic                      r_in_valid;
    t_opcode                   r_in_op;
    logic signed [SampleW-1:0] r_in_pred;
    logic [IndexW-1:0]         r_in_index;
    logic [7:0]                r_in_byte;

    logic signed [SampleW-1:0] r_pred;
    logic [IndexW-1:0]         r_index;

    logic                      r_out_valid;
    logic signed [SampleW-1:0] r_first;
    logic signed [SampleW-1:0] r_second;

    logic                      advance;
    logic                      in_accept;
    logic                      n_out_valid;
    logic signed [SampleW-1:0] s0;
    logic signed [SampleW-1:0] s1;
    logic [IndexW-1:0]         idx0;
    logic [IndexW-1:0]         idx1;

    // a header always moves on; a code byte waits for a free output register
    assign advance   = r_in_valid && (r_in_op == OP_HEADER || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    imabd_nibble u_low (
        .i_pred   (r_pred),
        .i_index  (r_index),
        .i_code   (r_in_byte[3:0]),
        .o_sample (s0),
        .o_index  (idx0)
    );

    imabd_nibble u_high (
        .i_pred   (s0),
        .i_index  (idx0),
        .i_code   (r_in_byte[7:4]),
        .o_sample (s1),
        .o_index  (idx1)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (advance && r_in_op == OP_CODE) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pred      <= '0;
            r_index     <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            r_out_valid <= n_out_valid;
            if (advance) begin
                if (r_in_op == OP_HEADER) begin
                    r_pred  <= r_in_pred;
                    r_index <= clamp_index(r_in_index);
                end else begin
                    r_pred  <= s1;
                    r_index <= idx1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op    <= t_opcode'(i_s_axis_tuser[0]);
            r_in_pred  <= i_s_axis_tdata[15:0];
            r_in_index <= i_s_axis_tdata[22:16];
            r_in_byte  <= i_s_axis_tdata[30:23];
        end
        if (advance && r_in_op == OP_CODE) begin
            r_first  <= s0;
            r_second <= s1;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_second, r_first};

endmodule

FILE: rtl/core/imabd_nibble.sv
// One IMA ADPCM nibble step: sample and next step index from one 4-bit code.
// Depends on imabd_pkg for the step table and index rule.
module imabd_nibble (
    input  logic signed [imabd_pkg::SampleW-1:0] i_pred,
    input  logic        [imabd_pkg::IndexW-1:0]  i_index,
    input  logic        [imabd_pkg::CodeW-1:0]   i_code,
    output logic signed [imabd_pkg::SampleW-1:0] o_sample,
    output logic        [imabd_pkg::IndexW-1:0]  o_index
);
    import imabd_pkg::*;

    logic [StepW-1:0]          step;
    logic [StepW+1:0]          diff;
    logic signed [SampleW+1:0] sum;
    logic signed [IndexW+1:0]  idx_sum;
    logic signed [4:0]         move;

    always_comb begin
        step = step_size(i_index);
        diff = {2'b00, step >> 3};
        if (i_code[0]) diff = diff + {2'b00, step >> 2};
        if (i_code[1]) diff = diff + {2'b00, step >> 1};
        if (i_code[2]) diff = diff + {2'b00, step};

        if (i_code[3]) begin
            sum = {{2{i_pred[SampleW-1]}}, i_pred} - $signed({1'b0, diff});
        end else begin
            sum = {{2{i_pred[SampleW-1]}}, i_pred} + $signed({1'b0, diff});
        end

        // saturate to the signed 16-bit range
        if (sum > 18'sd32767) begin
            o_sample = 16'sh7FFF;
        end else if (sum < -18'sd32768) begin
            o_sample = 16'sh8000;
        end else begin
            o_sample = sum[SampleW-1:0];
        end

        move    = index_move(i_code[2:0]);
        idx_sum = $signed({2'b00, clamp_index(i_index)})
                + $signed({{(IndexW-3){move[4]}}, move});
        if (idx_sum < 0) begin
            o_index = '0;
        end else if (idx_sum > $signed({2'b00, MaxStepPos})) begin
            o_index = MaxStepPos;
        end else begin
            o_index = idx_sum[IndexW-1:0];
        end
    end

endmodule

FILE: rtl/core/imabd_checker.sv
// Port-level checks for the IMA ADPCM block decoder, bound to the top level.
// Depends on imabd_pkg for the opcode names.
module imabd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [0:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata
);
    import imabd_pkg::*;

    // no result survives reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // input backpressure only comes from a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without output backpressure");

    // an accepted code beat reaches the output once the sink is ready
    a_code_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[0] == OP_CODE)
        ##1 i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("code beat produced no result");

endmodule

bind ima_adpcm_block_decoder imabd_checker u_imabd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: tb/testbench.sv
// Self-checking testbench for ima_adpcm_block_decoder: directed beats, then random blocks and lone beats.
// Keeps its own model of the nibble decoder and compares each sample pair as it leaves.
// Depends on imabd_pkg (opcode enum) and the decoder RTL.
`timescale 1ns / 100ps

module testbench;

    import imabd_pkg::*;

    localparam int NumRandomBeats = 850;
    localparam int NumDirected    = 20;

    typedef struct {
        logic signed [15:0] first;
        logic signed [15:0] second;
    } t_sample_pair;

    typedef struct {
        t_opcode     op;
        logic [15:0] seed_pred;
        logic [6:0]  seed_idx;
        logic [7:0]  code;
        bit          fixed;     // expected pair typed in below
        logic [15:0] exp_first;
        logic [15:0] exp_second;
    } t_directed_beat;

    localparam int STEP_LUT [0:88] = '{
        7, 8, 9, 10, 11, 12, 13, 14, 16, 17,
        19, 21, 23, 25, 28, 31, 34, 37, 41, 45,
        50, 55, 60, 66, 73, 80, 88, 97, 107, 118,
        130, 143, 157, 173, 190, 209, 230, 253, 279, 307,
        337, 371, 408, 449, 494, 544, 598, 658, 724, 796,
        876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066,
        2272, 2499, 2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358,
        5894, 6484, 7132, 7845, 8630, 9493, 10442, 11487, 12635, 13899,
        15289, 16818, 18500, 20350, 22385, 24623, 27086, 29794, 32767
    };

    localparam int INDEX_ADJUST [0:7] = '{-1, -1, -1, -1, 2, 4, 6, 8};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;  // seed_predictor, seed_index, code_byte, pad
    logic [0:0]  i_s_axis_tuser = '0;  // opcode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;       // first_sample, second_sample

    logic signed [15:0] dec_predictor = '0;
    logic [6:0]         dec_step_idx = '0;
    t_sample_pair       pending_samples [$];
    t_directed_beat     directed_beats [0:NumDirected-1];
    int                 tx_idle_pct = 17;
    int                 rx_idle_pct = 61;
    int                 error_count = 0;

    ima_adpcm_block_decoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Advance the decoder model by one nibble and return the new sample.
    function automatic logic signed [15:0] decode_nibble(input logic [3:0] code);
        int step;
        int diff;
        int sum;
        int next_idx;
        step = STEP_LUT[dec_step_idx];
        diff = step >>> 3;
        if (code[0]) diff += step >>> 2;
        if (code[1]) diff += step >>> 1;
        if (code[2]) diff += step;
        if (code[3]) diff = -diff;
        sum = int'(dec_predictor) + diff;
        if (sum > 32767) sum = 32767;
        else if (sum < -32768) sum = -32768;
        dec_predictor = sum[15:0];
        next_idx = int'(dec_step_idx) + INDEX_ADJUST[code[2:0]];
        if (next_idx < 0) next_idx = 0;
        else if (next_idx > 88) next_idx = 88;
        dec_step_idx = next_idx[6:0];
        return dec_predictor;
    endfunction

    task automatic send_beat(input t_opcode op, input logic [15:0] seed_pred,
                             input logic [6:0] seed_idx, input logic [7:0] code,
                             input bit fixed, input logic [15:0] exp_first,
                             input logic [15:0] exp_second);
        t_sample_pair pair;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, code, seed_idx, seed_pred};
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (op == OP_HEADER) begin
            dec_predictor = seed_pred;
            dec_step_idx  = (seed_idx > 7'd88) ? 7'd88 : seed_idx;
        end else begin
            pair.first  = decode_nibble(code[3:0]);
            pair.second = decode_nibble(code[7:4]);
            if (fixed) begin
                pair.first  = exp_first;
                pair.second = exp_second;
            end
            pending_samples.push_back(pair);
        end
    endtask

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Compare each sample pair that leaves the block against the oldest prediction.
    always @(posedge i_clk) begin
        t_sample_pair want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected output beat %h", o_m_axis_tdata);
                error_count++;
            end else begin
                want = pending_samples.pop_front();
                if (o_m_axis_tdata[15:0] !== want.first) begin
                    $error("first_sample expected %0d got %0d",
                           want.first, $signed(o_m_axis_tdata[15:0]));
                    error_count++;
                end
                if (o_m_axis_tdata[31:16] !== want.second) begin
                    $error("second_sample expected %0d got %0d",
                           want.second, $signed(o_m_axis_tdata[31:16]));
                    error_count++;
                end
            end
        end
    end

    initial begin
        int          beat_count;
        int          run_len;
        int          pick;
        logic [15:0] pred;
        logic [6:0]  idx;

        // Code bytes straight out of reset decode from predictor 0, index 0.
        directed_beats[0]  = '{OP_CODE,   16'h0000, 7'd0,   8'h00, 1'b1, 16'h0000, 16'h0000};
        directed_beats[1]  = '{OP_CODE,   16'hFFFF, 7'd127, 8'h80, 1'b1, 16'h0000, 16'h0000};
        // Largest step: both nibbles saturate high.
        directed_beats[2]  = '{OP_HEADER, 16'h7FFF, 7'd88,  8'hFF, 1'b0, 16'h0000, 16'h0000};
        directed_beats[3]  = '{OP_CODE,   16'h0000, 7'd0,   8'h77, 1'b1, 16'h7FFF, 16'h7FFF};
        directed_beats[4]  = '{OP_CODE,   16'h0000, 7'd0,   8'hFF, 1'b0, 16'h0000, 16'h0000};
        // Index 127 clamps to 88, then saturate low.
        directed_beats[5]  = '{OP_HEADER, 16'h8000, 7'd127, 8'h00, 1'b0, 16'h0000, 16'h0000};
        directed_beats[6]  = '{OP_CODE,   16'h0000, 7'd0,   8'hFF, 1'b1, 16'h8000, 16'h8000};
        directed_beats[7]  = '{OP_HEADER, 16'h0000, 7'd89,  8'h00, 1'b0, 16'h0000, 16'h0000};
        directed_beats[8]  = '{OP_CODE,   16'h0000, 7'd0,   8'h00, 1'b0, 16'h0000, 16'h0000};
        // Zero step magnitude: a negative zero diff leaves the predictor alone.
        directed_beats[9]  = '{OP_HEADER, 16'h0000, 7'd0,   8'hFF, 1'b0, 16'h0000, 16'h0000};
        directed_beats[10] = '{OP_CODE,   16'hFFFF, 7'd127, 8'h88, 1'b1, 16'h0000, 16'h0000};
        directed_beats[11] = '{OP_HEADER, 16'h1234, 7'd0,   8'h00, 1'b0, 16'h0000, 16'h0000};
        directed_beats[12] = '{OP_CODE,   16'h0000, 7'd0,   8'h01, 1'b0, 16'h0000, 16'h0000};
        directed_beats[13] = '{OP_CODE,   16'h0000, 7'd0,   8'h23, 1'b0, 16'h0000, 16'h0000};
        directed_beats[14] = '{OP_CODE,   16'h0000, 7'd0,   8'h45, 1'b0, 16'h0000, 16'h0000};
        directed_beats[15] = '{OP_CODE,   16'h0000, 7'd0,   8'h67, 1'b0, 16'h0000, 16'h0000};
        directed_beats[16] = '{OP_CODE,   16'h0000, 7'd0,   8'h89, 1'b0, 16'h0000, 16'h0000};
        directed_beats[17] = '{OP_CODE,   16'h0000, 7'd0,   8'hAB, 1'b0, 16'h0000, 16'h0000};
        directed_beats[18] = '{OP_HEADER, 16'hAAAA, 7'd85,  8'h55, 1'b0, 16'h0000, 16'h0000};
        directed_beats[19] = '{OP_CODE,   16'hFFFF, 7'd127, 8'hEF, 1'b0, 16'h0000, 16'h0000};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NumDirected; i++) begin
            send_beat(directed_beats[i].op, directed_beats[i].seed_pred,
                      directed_beats[i].seed_idx, directed_beats[i].code,
                      directed_beats[i].fixed, directed_beats[i].exp_first,
                      directed_beats[i].exp_second);
        end

        beat_count = 0;
        while (beat_count < NumRandomBeats) begin
            // Swap the idle mix by thirds of the random part.
            if (beat_count >= 2 * NumRandomBeats / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end else if (beat_count >= NumRandomBeats / 3) begin
                tx_idle_pct = 61;
                rx_idle_pct <= 17;
            end
            if ($urandom_range(0, 99) < 80) begin
                // Well-formed block: header then a run of code bytes.
                pick = $urandom_range(0, 99);
                if (pick < 10) pred = 16'h7FFF - 16'($urandom_range(0, 255));
                else if (pick < 20) pred = 16'h8000 + 16'($urandom_range(0, 255));
                else pred = 16'($urandom());
                pick = $urandom_range(0, 99);
                if (pick < 10) idx = 7'd0;
                else if (pick < 20) idx = 7'd88;
                else if (pick < 35) idx = 7'($urandom_range(89, 127));
                else idx = 7'($urandom_range(0, 88));
                send_beat(OP_HEADER, pred, idx, 8'($urandom()), 1'b0, '0, '0);
                beat_count++;
                run_len = $urandom_range(1, 12);
                for (int j = 0; j < run_len; j++) begin
                    send_beat(OP_CODE, 16'($urandom()), 7'($urandom()), 8'($urandom()),
                              1'b0, '0, '0);
                    beat_count++;
                end
            end else begin
                // Noise: a lone beat of either kind with all fields random.
                send_beat($urandom_range(0, 1) ? OP_CODE : OP_HEADER, 16'($urandom()),
                          7'($urandom()), 8'($urandom()), 1'b0, '0, '0);
                beat_count++;
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
